// ===== rtl/core/fcfs_pkg.sv =====
// Shared types, codes and defaults for the first-come-first-served scheduler.
package fcfs_pkg;

    localparam int READY_DEPTH_DEF = 16;
    localparam int WAIT_DEPTH_DEF  = 16;

    typedef enum logic [2:0] {
        CMD_ADD_TICK = 3'd0,
        CMD_TICK     = 3'd1,
        CMD_WAIT     = 3'd2,
        CMD_EVENT    = 3'd3,
        CMD_SHOW     = 3'd4,
        CMD_ADD      = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        STS_OK          = 3'd0,
        STS_READY_FULL  = 3'd1,
        STS_WAIT_FULL   = 3'd2,
        STS_NOT_RUNNING = 3'd3,
        STS_NOT_WAITING = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_SCAN,
        ST_READ,
        ST_TICK,
        ST_DONE
    } state_t;

    // One scheduler entry: priority, remaining burst and task id.
    typedef struct packed {
        logic [7:0]  prio;
        logic [15:0] left;
        logic [7:0]  id;
    } entry_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  task_id;
        logic [15:0] burst;
        logic [7:0]  priority_req;
    } req_t;

    typedef struct packed {
        logic        running_valid;
        logic [7:0]  running_id;
        logic [15:0] running_left;
        logic        finished_valid;
        logic [7:0]  finished_id;
        logic [2:0]  status;
    } rsp_t;

    // Controls of one cell in the waiting chain.
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    // Controls of the ready queue.
    typedef struct packed {
        logic push;
        logic pop;
        logic rd_en;
    } fifo_ctrl_t;

endpackage

// ===== rtl/core/fcfs_chan_if.sv =====
// Valid/ready channel interface carrying one request or result payload.
interface fcfs_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/fcfs_wait_cell.sv =====
// One cell of the waiting chain: holds an entry, loads a new one or takes its neighbour's.
module fcfs_wait_cell import fcfs_pkg::*; (
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     load_entry,
    input  entry_t     right_entry,
    output entry_t     entry
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load)
        begin
            entry_next = load_entry;
        end
        else if (ctrl.shift)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/core/fcfs_ready_fifo.sv =====
// Ready queue: circular buffer in a memory with head, tail and fill count.
module fcfs_ready_fifo import fcfs_pkg::*; #(
    parameter int DEPTH = READY_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  fifo_ctrl_t ctrl,
    input  entry_t     push_entry,
    output entry_t     rd_entry,
    output logic       full,
    output logic       empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    entry_t mem [DEPTH];
    entry_t rd_reg;

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.push)
        begin
            tail_next = (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + PW'(1);
        end
        if (ctrl.pop)
        begin
            head_next = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + PW'(1);
        end
        if (ctrl.push && !ctrl.pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctrl.pop && !ctrl.push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_reg] <= push_entry;
        end
        if (ctrl.rd_en)
        begin
            rd_reg <= mem[head_reg];
        end
    end

    assign rd_entry = rd_reg;
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push |-> !full)
        else $error("push into a full ready queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |-> !empty)
        else $error("pop from an empty ready queue");

endmodule

// ===== rtl/core/fcfs_process_scheduler.sv =====
// Top level of the first-come-first-served scheduler: control, ready queue, waiting chain and result register.
//
//   Port  Role    Payload  Content
//   req   sink    req_t    one command with task id, burst and priority
//   rsp   source   rsp_t    running slot, finished task and status per command
//
// A request is taken only when the controller is idle. From acceptance to the
// loaded result, show, add without tick and the unused codes pass the decode and
// done states; add with tick, tick and wait also pass the read and tick states,
// and an event with waiting entries first searches them: the waiting chain shifts
// one entry past the comparator per cycle. The next request can be taken in the
// cycle after the result is loaded, even while that result stalls.
// Reset clears the queue pointers, the counts and the running slot; the stores
// need no clearing pass. A stalled result holds the controller only until the
// output register is free.
module fcfs_process_scheduler import fcfs_pkg::*; #(
    parameter int READY_DEPTH = READY_DEPTH_DEF,
    parameter int WAIT_DEPTH  = WAIT_DEPTH_DEF
) (
    input logic          clk,
    input logic          rst_n,
    fcfs_chan_if.sink    req,
    fcfs_chan_if.source  rsp
);

    localparam int WIDX_W = $clog2(WAIT_DEPTH);
    localparam int WCNT_W = $clog2(WAIT_DEPTH + 1);

    state_t state_reg, state_next;

    // Latched request.
    logic [2:0]  cmd_reg,   cmd_next;
    logic [7:0]  id_reg,    id_next;
    logic [15:0] burst_reg, burst_next;
    logic [7:0]  prio_reg,  prio_next;

    // Scheduler state that is not in a store.
    logic        slot_valid_reg, slot_valid_next;
    entry_t      slot_entry_reg, slot_entry_next;
    logic [WCNT_W-1:0] wcount_reg, wcount_next;

    // Per-request working state.
    logic [WCNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic        found_reg,  found_next;
    logic [2:0]  status_reg, status_next;
    logic        fin_valid_reg, fin_valid_next;
    logic [7:0]  fin_id_reg, fin_id_next;

    // Result register.
    logic        out_valid_reg;
    rsp_t        out_data_reg;
    logic        out_load;

    // Ready queue.
    fifo_ctrl_t  fifo_ctrl;
    entry_t      fifo_push_entry;
    entry_t      fifo_rd_entry;
    logic        fifo_full;
    logic        fifo_empty;

    // Waiting chain.
    entry_t      cell_q [WAIT_DEPTH];
    logic        wpush;
    logic        wshift;
    logic [WIDX_W-1:0] widx;
    entry_t      wentry;
    logic [WCNT_W-1:0] wlast;
    logic        match;
    logic        has_tick;

    assign wlast    = wcount_reg - WCNT_W'(1);
    assign match    = (cell_q[0].id == id_reg) && !found_reg;
    assign has_tick = (cmd_reg == CMD_ADD_TICK) || (cmd_reg == CMD_TICK) ||
                      (cmd_reg == CMD_WAIT) || (cmd_reg == CMD_EVENT);

    fcfs_ready_fifo #(
        .DEPTH (READY_DEPTH)
    ) u_ready (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (fifo_ctrl),
        .push_entry (fifo_push_entry),
        .rd_entry   (fifo_rd_entry),
        .full       (fifo_full),
        .empty      (fifo_empty)
    );

    // The waiting list lives in a chain of cells, kept compacted from cell 0.
    // During an event search every cell takes its right neighbour each cycle;
    // the entry leaving cell 0 is either moved to the ready queue or written
    // back behind the last live entry, so arrival order is kept.
    for (genvar i = 0; i < WAIT_DEPTH; i++)
    begin : g_cell
        cell_ctrl_t cctrl;
        entry_t     right;

        if (i == WAIT_DEPTH - 1)
        begin : g_last
            assign right = cell_q[i];
        end
        else
        begin : g_mid
            assign right = cell_q[i + 1];
        end

        assign cctrl.shift = wshift;
        assign cctrl.load  = wpush && (widx == WIDX_W'(i));

        fcfs_wait_cell u_cell (
            .clk         (clk),
            .ctrl        (cctrl),
            .load_entry  (wentry),
            .right_entry (right),
            .entry       (cell_q[i])
        );
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_CMD;
                end
            end
            ST_CMD:
            begin
                if ((cmd_reg == CMD_EVENT) && (wcount_reg != '0))
                begin
                    state_next = ST_SCAN;
                end
                else if (has_tick)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == WCNT_W'(1))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_TICK;
            end
            ST_TICK:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath control and next values.
    always_comb
    begin
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        burst_next      = burst_reg;
        prio_next       = prio_reg;
        slot_valid_next = slot_valid_reg;
        slot_entry_next = slot_entry_reg;
        wcount_next     = wcount_reg;
        scan_cnt_next   = scan_cnt_reg;
        found_next      = found_reg;
        status_next     = status_reg;
        fin_valid_next  = fin_valid_reg;
        fin_id_next     = fin_id_reg;
        fifo_ctrl       = '0;
        fifo_push_entry = cell_q[0];
        wpush           = 1'b0;
        wshift          = 1'b0;
        widx            = wcount_reg[WIDX_W-1:0];
        wentry          = slot_entry_reg;
        out_load        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next       = req.data.command;
                    id_next        = req.data.task_id;
                    burst_next     = req.data.burst;
                    prio_next      = req.data.priority_req;
                    status_next    = STS_OK;
                    fin_valid_next = 1'b0;
                    fin_id_next    = '0;
                    found_next     = 1'b0;
                end
            end
            ST_CMD:
            begin
                case (cmd_reg)
                    CMD_ADD_TICK, CMD_ADD:
                    begin
                        if (fifo_full)
                        begin
                            status_next = STS_READY_FULL;
                        end
                        else
                        begin
                            fifo_ctrl.push  = 1'b1;
                            fifo_push_entry = '{prio: prio_reg, left: burst_reg, id: id_reg};
                        end
                    end
                    CMD_WAIT:
                    begin
                        if (!slot_valid_reg)
                        begin
                            status_next = STS_NOT_RUNNING;
                        end
                        else if (wcount_reg == WCNT_W'(WAIT_DEPTH))
                        begin
                            status_next = STS_WAIT_FULL;
                        end
                        else
                        begin
                            wpush           = 1'b1;
                            wcount_next     = wcount_reg + WCNT_W'(1);
                            slot_valid_next = 1'b0;
                            slot_entry_next = '0;
                        end
                    end
                    CMD_EVENT:
                    begin
                        if (wcount_reg == '0)
                        begin
                            status_next = STS_NOT_WAITING;
                        end
                        else
                        begin
                            scan_cnt_next = wcount_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SCAN:
            begin
                wshift        = 1'b1;
                scan_cnt_next = scan_cnt_reg - WCNT_W'(1);
                widx          = wlast[WIDX_W-1:0];
                wentry        = cell_q[0];
                if (match)
                begin
                    found_next = 1'b1;
                end
                if (match && !fifo_full)
                begin
                    // First match leaves the chain for the ready tail.
                    fifo_ctrl.push = 1'b1;
                    wcount_next    = wlast;
                end
                else
                begin
                    wpush = 1'b1;
                    if (match)
                    begin
                        status_next = STS_READY_FULL;
                    end
                end
                if ((scan_cnt_reg == WCNT_W'(1)) && !found_reg && !match)
                begin
                    status_next = STS_NOT_WAITING;
                end
            end
            ST_READ:
            begin
                fifo_ctrl.rd_en = 1'b1;
            end
            ST_TICK:
            begin
                if (slot_valid_reg && (slot_entry_reg.left > 16'd1))
                begin
                    slot_entry_next.left = slot_entry_reg.left - 16'd1;
                end
                else
                begin
                    if (slot_valid_reg)
                    begin
                        fin_valid_next  = 1'b1;
                        fin_id_next     = slot_entry_reg.id;
                    end
                    // Empty or just finished slot: the ready head moves in.
                    if (!fifo_empty)
                    begin
                        fifo_ctrl.pop   = 1'b1;
                        slot_valid_next = 1'b1;
                        slot_entry_next = fifo_rd_entry;
                    end
                    else
                    begin
                        slot_valid_next = 1'b0;
                        slot_entry_next = '0;
                    end
                end
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || rsp.ready;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slot_valid_reg <= 1'b0;
            slot_entry_reg <= '0;
            wcount_reg     <= '0;
            scan_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_valid_reg <= slot_valid_next;
            slot_entry_reg <= slot_entry_next;
            wcount_reg     <= wcount_next;
            scan_cnt_reg   <= scan_cnt_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        id_reg        <= id_next;
        burst_reg     <= burst_next;
        prio_reg      <= prio_next;
        found_reg     <= found_next;
        status_reg    <= status_next;
        fin_valid_reg <= fin_valid_next;
        fin_id_reg    <= fin_id_next;
        if (out_load)
        begin
            out_data_reg.running_valid  <= slot_valid_reg;
            out_data_reg.running_id     <= slot_valid_reg ? slot_entry_reg.id : 8'd0;
            out_data_reg.running_left   <= slot_valid_reg ? slot_entry_reg.left : 16'd0;
            out_data_reg.finished_valid <= fin_valid_reg;
            out_data_reg.finished_id    <= fin_id_reg;
            out_data_reg.status         <= status_reg;
        end
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    a_wcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wcount_reg <= WCNT_W'(WAIT_DEPTH))
        else $error("waiting count beyond its depth");

    a_scan_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_cnt_reg != '0))
        else $error("search running with no entries left");

    a_accept_to_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == ST_CMD))
        else $error("accepted request not decoded");

endmodule
